// ===== hw/rtl/deq_pkg.sv =====
// Shared types, sizes and operation codes for the double-ended queue.
`timescale 1ns / 1ps

package deq_pkg;

	// Storage geometry.
	localparam int unsigned DEPTH = 16384;
	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned DW = 32;

	// Port field widths.
	localparam int unsigned KIND_W = 3;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned COUNT_OUT_W = 15;

	typedef logic [AW-1:0] idx_t;
	typedef logic [CW-1:0] cnt_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_PUSH_FRONT = 3'd0,
		KIND_PUSH_BACK  = 3'd1,
		KIND_POP_FRONT  = 3'd2,
		KIND_POP_BACK   = 3'd3,
		KIND_PEEK_FRONT = 3'd4,
		KIND_PEEK_BACK  = 3'd5
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Request from the pointer logic to the word store.
	typedef struct packed {
		logic          we;
		logic          re;
		idx_t          addr;
		logic [DW-1:0] wdata;
	} mem_req_t;

	// What the pointer logic knows about a result at accept time.
	typedef struct packed {
		status_t status;
		logic    use_rd;
		cnt_t    count;
	} res_info_t;

endpackage

// ===== hw/rtl/deq_ram.sv =====
// Single-port synchronous RAM with a registered read port.
`timescale 1ns / 1ps

module deq_ram #(
	parameter int unsigned ADDR_W = 14,
	parameter int unsigned DATA_W = 32
) (
	input  logic              clk,
	input  logic              we,
	input  logic              re,
	input  logic [ADDR_W-1:0] addr,
	input  logic [DATA_W-1:0] wdata,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	// Write, or registered read; read data holds otherwise.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

// ===== hw/rtl/deq_ctrl.sv =====
// Head and tail pointers, word count and per-operation decisions.
`timescale 1ns / 1ps

module deq_ctrl
	import deq_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [KIND_W-1:0]   kind,
	input  logic signed [DW-1:0] push_value,
	output mem_req_t            mem_req,
	output res_info_t           info
);

	idx_t head_q, head_d, tail_q, tail_d;
	cnt_t count_q, count_d;
	idx_t head_prev, head_next, tail_prev, tail_next;
	logic full, empty;
	mem_req_t req_c;

	// Circular neighbors of both pointers.
	always_comb begin
		head_prev = (head_q == '0) ? AW'(DEPTH - 1) : head_q - 1'b1;
		head_next = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
		tail_prev = (tail_q == '0) ? AW'(DEPTH - 1) : tail_q - 1'b1;
		tail_next = (tail_q == AW'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
		full = (count_q == CW'(DEPTH));
		empty = (count_q == '0);
	end

	// Decide the operation, its memory access and the next pointer state.
	always_comb begin
		head_d = head_q;
		tail_d = tail_q;
		count_d = count_q;
		req_c = '0;
		req_c.wdata = push_value;
		info.status = ST_OK;
		info.use_rd = 1'b0;
		unique case (kind_t'(kind))
			KIND_PUSH_FRONT: begin
				if (full) begin
					info.status = ST_FULL;
				end else begin
					head_d = head_prev;
					req_c.we = 1'b1;
					req_c.addr = head_prev;
					count_d = count_q + 1'b1;
				end
			end
			KIND_PUSH_BACK: begin
				if (full) begin
					info.status = ST_FULL;
				end else begin
					tail_d = tail_next;
					req_c.we = 1'b1;
					req_c.addr = tail_q;
					count_d = count_q + 1'b1;
				end
			end
			KIND_POP_FRONT, KIND_PEEK_FRONT: begin
				if (empty) begin
					info.status = ST_EMPTY;
				end else begin
					req_c.re = 1'b1;
					req_c.addr = head_q;
					info.use_rd = 1'b1;
					if (kind_t'(kind) == KIND_POP_FRONT) begin
						head_d = head_next;
						count_d = count_q - 1'b1;
					end
				end
			end
			KIND_POP_BACK, KIND_PEEK_BACK: begin
				if (empty) begin
					info.status = ST_EMPTY;
				end else begin
					req_c.re = 1'b1;
					req_c.addr = tail_prev;
					info.use_rd = 1'b1;
					if (kind_t'(kind) == KIND_POP_BACK) begin
						tail_d = tail_prev;
						count_d = count_q - 1'b1;
					end
				end
			end
			default: begin
				// Unused codes leave the deque alone and report its state.
			end
		endcase
		info.count = count_d;
	end

	// Only an accepted transaction reaches the store.
	always_comb begin
		mem_req = req_c;
		mem_req.we = accept & req_c.we;
		mem_req.re = accept & req_c.re;
	end

	// Pointer and count registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			head_q <= head_d;
			tail_q <= tail_d;
			count_q <= count_d;
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("word count exceeds depth");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (head_q == tail_q))
		else $error("empty deque with unequal pointers");

	a_full_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == CW'(DEPTH)) |-> (head_q == tail_q))
		else $error("full deque with unequal pointers");

	a_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_req.we && mem_req.re))
		else $error("read and write issued together");
`endif

endmodule

// ===== hw/rtl/double_ended_queue.sv =====
// Top level of the double-ended queue: store, pointer logic and result stages.
//
// Usage: each request transaction carries kind (push front/back, pop
// front/back, peek front/back) and push_value. Each request yields exactly
// one response transaction with status, item_value, entry_count and is_empty.
// Both channels use valid and stall; a transaction moves on a rising edge
// with valid high and stall low.
// Stages: two register stages, one for the synchronous read of the word
// store and one for the output register; a taken request moves from the
// read stage into the output register, where the response becomes valid.
// Throughput: one request per cycle while req_stall is low. Pointers and
// count update when the request is taken, so the next request sees them at
// once; a write lands in the store before any later read of the same word.
// Reset clears the pointers, the count and both stage valids; the store
// itself needs no clearing, since only written words are ever read.
// When the response side stalls, the output register holds, the read stage
// holds behind it, and req_stall rises once both are occupied.
`timescale 1ns / 1ps

module double_ended_queue
	import deq_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  logic [KIND_W-1:0]            kind,
	input  logic signed [DW-1:0]         push_value,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output logic [STATUS_W-1:0]          status,
	output logic signed [DW-1:0]         item_value,
	output logic [COUNT_OUT_W-1:0]       entry_count,
	output logic                         is_empty
);

	logic      accept;
	mem_req_t  mem_req;
	res_info_t info;
	logic [DW-1:0] rd_data;

	logic      s1_valid_q;
	res_info_t info_s1;
	logic      out_free, s1_adv;

	status_t   status_q;
	logic [DW-1:0] item_q;
	cnt_t      count_q;

	// Handshake: the read stage moves on when the output register is free.
	assign out_free = !rsp_valid || !rsp_stall;
	assign s1_adv = s1_valid_q && out_free;
	assign req_stall = s1_valid_q && !s1_adv;
	assign accept = req_valid && !req_stall;

	deq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.kind       (kind),
		.push_value (push_value),
		.mem_req    (mem_req),
		.info       (info)
	);

	deq_ram #(
		.ADDR_W (AW),
		.DATA_W (DW)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.re    (mem_req.re),
		.addr  (mem_req.addr),
		.wdata (mem_req.wdata),
		.rdata (rd_data)
	);

	// Stage valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			rsp_valid <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				rsp_valid <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	// Stage payloads; the read data is picked up as it leaves the store.
	always_ff @(posedge clk) begin
		if (accept) begin
			info_s1 <= info;
		end
		if (s1_adv) begin
			status_q <= info_s1.status;
			item_q <= info_s1.use_rd ? rd_data : '0;
			count_q <= info_s1.count;
		end
	end

	assign status = status_q;
	assign item_value = item_q;
	assign entry_count = COUNT_OUT_W'(count_q);
	assign is_empty = (count_q == '0);

`ifndef SYNTH
	a_err_no_item: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status_q != ST_OK) |-> (item_value == '0))
		else $error("failed operation returned a word");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status_q == ST_FULL) |-> (count_q == CW'(DEPTH)))
		else $error("push refused below full");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status_q == ST_EMPTY) |-> is_empty)
		else $error("empty status with words stored");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_adv) |=> s1_valid_q)
		else $error("read stage lost a transaction while blocked");
`endif

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the double-ended queue.
`timescale 1ns / 1ps

module tb;
	import deq_pkg::*;

	// Kind codes 6 and 7 have no operation behind them.
	localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
	localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
	localparam int unsigned RANDOM_PER_PHASE = 580;
	localparam int unsigned PRINT_CAP = 40;

	typedef struct {
		status_t                status;
		logic signed [DW-1:0]   value;
		logic [COUNT_OUT_W-1:0] count;
		logic                   empty;
	} result_t;

	typedef struct {
		logic [KIND_W-1:0]    op;
		logic signed [DW-1:0] word;
		bit                   typed;
		result_t              want;
	} dir_row_t;

	logic                         clk;
	logic                         arst_n;
	logic                         req_valid;
	logic                         req_stall;
	logic [KIND_W-1:0]            kind;
	logic signed [DW-1:0]         push_value;
	logic                         rsp_valid;
	logic                         rsp_stall = 1'b0;
	logic [STATUS_W-1:0]          status;
	logic signed [DW-1:0]         item_value;
	logic [COUNT_OUT_W-1:0]       entry_count;
	logic                         is_empty;

	// Shadow deque state, updated when a request transaction is taken.
	logic signed [DW-1:0] words [DEPTH];
	int unsigned front_idx = 0;
	int unsigned back_idx = 0;
	int unsigned occupancy = 0;
	int unsigned peak_occupancy = 0;

	result_t pending_results [$];
	result_t no_want;
	int unsigned send_idle_pct = 0;
	int unsigned rsp_idle_pct = 0;
	int unsigned mismatches = 0;
	int unsigned requests_sent = 0;
	int unsigned responses_seen = 0;
	int unsigned full_hits = 0;
	int unsigned empty_hits = 0;
	int unsigned spare_hits = 0;

	dir_row_t directed_ops [23];

	double_ended_queue u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.kind       (kind),
		.push_value (push_value),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.status     (status),
		.item_value (item_value),
		.entry_count(entry_count),
		.is_empty   (is_empty)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard limit on run time.
	initial begin
		#20ms;
		$display("status: fail");
		$finish;
	end

	// Apply one operation to the shadow deque and return the response it should produce.
	function automatic result_t deque_apply(input logic [KIND_W-1:0] op,
			input logic signed [DW-1:0] word);
		result_t r;
		int unsigned last;
		r.status = ST_OK;
		r.value = '0;
		case (op)
			KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
				if (occupancy >= DEPTH) begin
					r.status = ST_FULL;
					full_hits++;
				end else if (op == KIND_PUSH_FRONT) begin
					front_idx = (front_idx == 0) ? DEPTH - 1 : front_idx - 1;
					words[front_idx] = word;
					occupancy++;
				end else begin
					words[back_idx] = word;
					back_idx = (back_idx == DEPTH - 1) ? 0 : back_idx + 1;
					occupancy++;
				end
			end
			KIND_POP_FRONT, KIND_PEEK_FRONT: begin
				if (occupancy == 0) begin
					r.status = ST_EMPTY;
					empty_hits++;
				end else begin
					r.value = words[front_idx];
					if (op == KIND_POP_FRONT) begin
						front_idx = (front_idx == DEPTH - 1) ? 0 : front_idx + 1;
						occupancy--;
					end
				end
			end
			KIND_POP_BACK, KIND_PEEK_BACK: begin
				if (occupancy == 0) begin
					r.status = ST_EMPTY;
					empty_hits++;
				end else begin
					last = (back_idx == 0) ? DEPTH - 1 : back_idx - 1;
					r.value = words[last];
					if (op == KIND_POP_BACK) begin
						back_idx = last;
						occupancy--;
					end
				end
			end
			default: begin
				spare_hits++;
			end
		endcase
		if (occupancy > peak_occupancy)
			peak_occupancy = occupancy;
		r.count = occupancy[COUNT_OUT_W-1:0];
		r.empty = (occupancy == 0);
		return r;
	endfunction

	// Print one mismatch line (up to a cap) and count it.
	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	// Present one request and hold it until taken; called and left at a falling edge.
	task automatic drive_op(input logic [KIND_W-1:0] op, input logic signed [DW-1:0] word,
			input bit typed, input result_t want);
		result_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		kind <= op;
		push_value <= word;
		do
			@(posedge clk);
		while (req_stall);
		predicted = deque_apply(op, word);
		pending_results.insert(pending_results.size(), typed ? want : predicted);
		requests_sent++;
		@(negedge clk);
	endtask

	// Pick a kind; a growing burst favors pushes, a shrinking one favors pops.
	function automatic logic [KIND_W-1:0] pick_kind(input bit grow);
		int unsigned r;
		r = $urandom_range(99);
		if (r < 3)
			return $urandom_range(1) ? KIND_SPARE_HI : KIND_SPARE_LO;
		if (r < (grow ? 63 : 28))
			return $urandom_range(1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
		if (r < (grow ? 90 : 85))
			return $urandom_range(1) ? KIND_POP_BACK : KIND_POP_FRONT;
		return $urandom_range(1) ? KIND_PEEK_BACK : KIND_PEEK_FRONT;
	endfunction

	// Mostly random words, with the extremes mixed in.
	function automatic logic signed [DW-1:0] pick_word();
		case ($urandom_range(19))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return -32'sd1;
			3: return 32'sd0;
			default: return $urandom;
		endcase
	endfunction

	// Receiver stall, redrawn at every falling edge.
	always @(negedge clk)
		rsp_stall <= ($urandom_range(99) < rsp_idle_pct);

	// Compare every response transaction with the oldest pending result.
	always @(posedge clk) begin : check_rsp
		result_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			responses_seen++;
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected response, status", status, -1);
			end else begin
				want = pending_results[0];
				pending_results.delete(0);
				if (status !== want.status)
					report_mismatch("status", status, want.status);
				if (item_value !== want.value)
					report_mismatch("item_value", item_value, want.value);
				if (entry_count !== want.count)
					report_mismatch("entry_count", entry_count, want.count);
				if (is_empty !== want.empty)
					report_mismatch("is_empty", is_empty, want.empty);
			end
		end
	end

	// Main stimulus sequence.
	initial begin : stimulus
		int unsigned left;
		int unsigned run;
		bit grow;
		logic [KIND_W-1:0] op;

		arst_n = 1'b0;
		req_valid = 1'b0;
		kind = '0;
		push_value = '0;
		no_want = '{ST_OK, '0, '0, 1'b0};

		// Empty checks, spare codes, extremes, a stored minus one, index wrap at the front.
		directed_ops = '{
			'{KIND_POP_FRONT,  32'sd0,          1'b1, '{ST_EMPTY, 32'sd0, 15'd0, 1'b1}},
			'{KIND_POP_BACK,   32'sd0,          1'b1, '{ST_EMPTY, 32'sd0, 15'd0, 1'b1}},
			'{KIND_PEEK_FRONT, 32'sd0,          1'b1, '{ST_EMPTY, 32'sd0, 15'd0, 1'b1}},
			'{KIND_PEEK_BACK,  32'sd0,          1'b1, '{ST_EMPTY, 32'sd0, 15'd0, 1'b1}},
			'{KIND_SPARE_LO,   32'sd5,          1'b1, '{ST_OK, 32'sd0, 15'd0, 1'b1}},
			'{KIND_PUSH_FRONT, 32'sh7FFF_FFFF,  1'b1, '{ST_OK, 32'sd0, 15'd1, 1'b0}},
			'{KIND_PUSH_BACK,  32'sh8000_0000,  1'b1, '{ST_OK, 32'sd0, 15'd2, 1'b0}},
			'{KIND_PUSH_FRONT, -32'sd1,         1'b1, '{ST_OK, 32'sd0, 15'd3, 1'b0}},
			'{KIND_PEEK_FRONT, 32'sd0,          1'b1, '{ST_OK, -32'sd1, 15'd3, 1'b0}},
			'{KIND_PEEK_BACK,  32'sd0,          1'b1, '{ST_OK, 32'sh8000_0000, 15'd3, 1'b0}},
			'{KIND_SPARE_HI,   -32'sd1,         1'b1, '{ST_OK, 32'sd0, 15'd3, 1'b0}},
			'{KIND_POP_FRONT,  32'sd0,          1'b1, '{ST_OK, -32'sd1, 15'd2, 1'b0}},
			'{KIND_POP_BACK,   32'sd0,          1'b1, '{ST_OK, 32'sh8000_0000, 15'd1, 1'b0}},
			'{KIND_PUSH_BACK,  -32'sd1,         1'b1, '{ST_OK, 32'sd0, 15'd2, 1'b0}},
			'{KIND_POP_BACK,   32'sd0,          1'b1, '{ST_OK, -32'sd1, 15'd1, 1'b0}},
			'{KIND_POP_FRONT,  32'sd0,          1'b1, '{ST_OK, 32'sh7FFF_FFFF, 15'd0, 1'b1}},
			'{KIND_PEEK_BACK,  32'sd0,          1'b1, '{ST_EMPTY, 32'sd0, 15'd0, 1'b1}},
			'{KIND_PUSH_BACK,  32'sd0,          1'b1, '{ST_OK, 32'sd0, 15'd1, 1'b0}},
			'{KIND_PUSH_FRONT, 32'sh5555_5555,  1'b0, no_want},
			'{KIND_PUSH_BACK,  32'shAAAA_AAAA,  1'b0, no_want},
			'{KIND_POP_BACK,   32'sd0,          1'b0, no_want},
			'{KIND_POP_FRONT,  32'sd0,          1'b0, no_want},
			'{KIND_POP_FRONT,  32'sd0,          1'b0, no_want}
		};

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Phase one: sender idles a quarter of the time, receiver over half.
		send_idle_pct = 25;
		rsp_idle_pct = 56;
		foreach (directed_ops[i])
			drive_op(directed_ops[i].op, directed_ops[i].word, directed_ops[i].typed,
				directed_ops[i].want);

		// Random bursts that grow or shrink the deque, under three idling patterns.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin send_idle_pct = 25; rsp_idle_pct = 56; end
				1: begin send_idle_pct = 56; rsp_idle_pct = 25; end
				default: begin send_idle_pct = 0; rsp_idle_pct = 0; end
			endcase
			left = RANDOM_PER_PHASE;
			while (left > 0) begin
				grow = $urandom_range(1);
				run = $urandom_range(64, 16);
				repeat (run) begin
					if (left > 0) begin
						op = pick_kind(grow);
						drive_op(op, pick_word(), 1'b0, no_want);
						if (op != KIND_SPARE_LO && op != KIND_SPARE_HI)
							left--;
					end
				end
			end
		end
		req_valid <= 1'b0;

		// Let the last responses come out, then keep watching for strays.
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Sent %0d requests and checked %0d responses; peak occupancy %0d of %0d.",
			requests_sent, responses_seen, peak_occupancy, DEPTH);
		$display("Results on an empty deque: %0d, on a full deque: %0d, spare codes: %0d.",
			empty_hits, full_hits, spare_hits);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/deq_pkg.sv
hw/rtl/deq_ram.sv
hw/rtl/deq_ctrl.sv
hw/rtl/double_ended_queue.sv
test/tb.sv
